@@ sv/roaring_bitmap_stream_decoder_top_macros.svh @@
// Assertion helpers used by the decoder back end.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ROARING_BITMAP_STREAM_DECODER_TOP_MACROS_SVH
`define ROARING_BITMAP_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rbsd_pkg.sv @@
package rbsd_pkg;

  localparam int unsigned MAX_CONTAINERS_DEF = 65536;
  localparam logic [32:0] DEFAULT_BUDGET_DEF = 33'h0_8000_0000;

  localparam logic [15:0] COOKIE_RUNS  = 16'd12347;
  localparam logic [31:0] COOKIE_PLAIN = 32'd12346;
  localparam logic [16:0] OFFSET_MIN   = 17'd4;
  localparam logic [18:0] BITMAP_BYTES = 19'd8192;
  localparam logic [16:0] ARRAY_MAX    = 17'd4096;
  localparam logic [17:0] KEY_SPAN     = 18'd65536;

  // Section byte counter width: covers the offset header of 4 bytes per container.
  localparam int unsigned SBW = 19;

  // Parse phases.
  localparam logic [3:0] PH_COOKIE   = 4'd0;
  localparam logic [3:0] PH_COUNT    = 4'd1;
  localparam logic [3:0] PH_FLAGS    = 4'd2;
  localparam logic [3:0] PH_DESC     = 4'd3;
  localparam logic [3:0] PH_OFFSETS  = 4'd4;
  localparam logic [3:0] PH_RUNCOUNT = 4'd5;
  localparam logic [3:0] PH_RUNS     = 4'd6;
  localparam logic [3:0] PH_BITMAP   = 4'd7;
  localparam logic [3:0] PH_ARRAY    = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;
  localparam logic [3:0] PH_HALT     = 4'd10;
  localparam logic [3:0] PH_BEGIN    = 4'd11;

  // Status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TRUNC = 3'd1;
  localparam logic [2:0] ST_COOKIE = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;
  localparam logic [2:0] ST_CARD  = 3'd5;
  localparam logic [2:0] ST_ORDER = 3'd6;

  // Result kinds.
  localparam logic KIND_RANGE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

@@ sv/roaring_bitmap_stream_decoder_top.sv @@
// Path: a beat passes the front queue, the byte register, the holding slot and the
// output register; a container start adds a descriptor read. The back end takes a
// new byte only once it is through with the last; a bitmap byte yields one range
// per set bit. The sequencer and its single output register set the pace.
// Reset: synchronous active-low rst_n clears the queue, the parse state and the budget.
module roaring_bitmap_stream_decoder_top
  import rbsd_pkg::*;
#(
  parameter int unsigned MAX_CONTAINERS = MAX_CONTAINERS_DEF,
  parameter logic [32:0] DEFAULT_BUDGET = DEFAULT_BUDGET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [32:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [31:0] out_range_start,
  output logic [16:0] out_range_count,
  output logic [2:0]  out_status,
  output logic        out_last_result
);

  // The front end buffers input beats in a two-entry queue, so the input side runs
  // ahead while the back end expands a container or waits on the output.
  queue_head_t head;
  logic        pop;

  rbsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .head           (head),
    .pop            (pop)
  );

  // The back end walks the serialized layout: cookie, a count or (with runs) run flags,
  // descriptors, offsets, then each container. Ranges pass through a one-deep
  // holding slot so the last range of a beat can be marked before it leaves,
  // and a status beat follows the ranges of the final byte.
  rbsd_back #(
    .MAX_CONTAINERS (MAX_CONTAINERS),
    .DEFAULT_BUDGET (DEFAULT_BUDGET)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_range_start (out_range_start),
    .out_range_count (out_range_count),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

endmodule

@@ sv/rbsd_front.sv @@
module rbsd_front
  import rbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output queue_head_t head,
  input  logic        pop
);

  // Two-entry queue of incoming beats.
  item_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       do_pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data: in_data_byte, eof: in_end_of_file};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/rbsd_back.sv @@
`include "roaring_bitmap_stream_decoder_top_macros.svh"
module rbsd_back
  import rbsd_pkg::*;
#(
  parameter int unsigned MAX_CONTAINERS = MAX_CONTAINERS_DEF,
  parameter logic [32:0] DEFAULT_BUDGET = DEFAULT_BUDGET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [32:0] cfg_wdata,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [31:0] out_range_start,
  output logic [16:0] out_range_count,
  output logic [2:0]  out_status,
  output logic        out_last_result
);

  localparam int unsigned DAW    = (MAX_CONTAINERS > 1) ? $clog2(MAX_CONTAINERS) : 1;
  localparam int unsigned FDEPTH = (MAX_CONTAINERS + 7) / 8;
  localparam int unsigned FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam logic [16:0] MAXC   = 17'(MAX_CONTAINERS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_WORK  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;

  logic [31:0] desc_mem [MAX_CONTAINERS];
  logic [7:0]  flag_mem [FDEPTH];
  logic [31:0] desc_q_r;
  logic [7:0]  flag_q_r;
  logic [2:0]  fsel_r;

  logic        desc_we, flag_we;
  logic [31:0] desc_wd;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  ph_r, ph_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [SBW-1:0] sbc_r, sbc_nxt;
  logic [16:0] tot_r, tot_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic        runs_r, runs_nxt;
  logic [15:0] rl_r, rl_nxt;
  logic [16:0] cvc_r, cvc_nxt;
  logic [32:0] dsum_r, dsum_nxt;
  logic [32:0] esum_r, esum_nxt;
  logic [32:0] nmin_r, nmin_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        eof_r, eof_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [31:0] pend_start_r, pend_start_nxt;
  logic [16:0] pend_cnt_r, pend_cnt_nxt;
  logic [32:0] budget_r;

  logic        out_valid_r;
  logic        out_kind_r, out_last_r;
  logic [31:0] out_start_r;
  logic [16:0] out_cnt_r;
  logic [2:0]  out_st_r;
  logic        out_load, out_free;
  logic        ld_kind, ld_last;
  logic [31:0] ld_start;
  logic [16:0] ld_cnt;
  logic [2:0]  ld_st;

  logic [32:0] bud;
  logic [15:0] key;
  logic [16:0] card;

  assign bud  = (budget_r == 33'd0) ? DEFAULT_BUDGET : budget_r;
  assign key  = desc_q_r[31:16];
  assign card = {1'b0, desc_q_r[15:0]} + 17'd1;
  assign out_free = !out_valid_r || out_ready;

  // Range checks in the order budget, key span, ordering.
  function automatic logic [2:0] em_check(input logic [15:0] low, input logic [16:0] cnt,
                                          input logic [15:0] k, input logic [32:0] es,
                                          input logic [32:0] nm, input logic [32:0] b);
    logic [32:0] start;
    logic [33:0] sum;
    logic [17:0] span;
    start = {1'b0, k, 16'd0} + {17'd0, low};
    sum   = {1'b0, es} + {17'd0, cnt};
    span  = {2'b0, low} + {1'b0, cnt};
    if (sum > {1'b0, b}) begin
      return ST_OVER;
    end else if (span > KEY_SPAN) begin
      return ST_CARD;
    end else if (start < nm) begin
      return ST_ORDER;
    end
    return ST_OK;
  endfunction

  always_comb begin
    logic [31:0] asm_g;
    logic [SBW-1:0] sbc_p1;
    logic [2:0]  chk;
    logic [2:0]  bit_i;
    logic        bit_f;
    logic        wdone;
    logic        may_emit;
    logic        em_do;
    logic [15:0] em_low;
    logic [16:0] em_cnt;
    logic [31:0] em_start;
    logic [17:0] cvc_s;
    logic        do_end, do_bdesc, do_offs, do_fin, do_begin, do_take;
    logic [3:0]  ph_take;
    logic [2:0]  fstat;

    st_nxt = st_r; ph_nxt = ph_r; asm_nxt = asm_r; sbc_nxt = sbc_r;
    tot_nxt = tot_r; idx_nxt = idx_r; runs_nxt = runs_r; rl_nxt = rl_r;
    cvc_nxt = cvc_r; dsum_nxt = dsum_r; esum_nxt = esum_r; nmin_nxt = nmin_r;
    err_nxt = err_r; byte_nxt = byte_r; eof_nxt = eof_r; mask_nxt = mask_r;
    pend_v_nxt = pend_v_r; pend_start_nxt = pend_start_r; pend_cnt_nxt = pend_cnt_r;
    desc_we = 1'b0; flag_we = 1'b0; desc_wd = '0;
    out_load = 1'b0; ld_kind = KIND_RANGE; ld_last = 1'b0;
    ld_start = '0; ld_cnt = '0; ld_st = ST_OK;
    pop = 1'b0;
    asm_g  = asm_r | ({24'd0, byte_r} << {sbc_r[1:0], 3'b000});
    sbc_p1 = sbc_r + 1'b1;
    chk = ST_OK; bit_i = 3'd0; bit_f = 1'b0; wdone = 1'b1; em_do = 1'b0;
    em_low = '0; em_cnt = '0; em_start = '0; cvc_s = '0;
    do_end = 1'b0; do_bdesc = 1'b0; do_offs = 1'b0; do_fin = 1'b0;
    do_begin = 1'b0; do_take = 1'b0; ph_take = ph_r; fstat = ST_OK;

    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) begin
        bit_i = 3'(i);
        bit_f = 1'b1;
      end
    end
    may_emit = ((ph_r == PH_RUNS) && (sbc_r[1:0] == 2'd3)) ||
               ((ph_r == PH_ARRAY) && sbc_r[0]) ||
               ((ph_r == PH_BITMAP) && bit_f);

    unique case (st_r)
      S_IDLE: begin
        do_take = 1'b1;
      end
      S_FETCH: begin
        if (runs_r && flag_q_r[fsel_r]) begin
          ph_nxt = PH_RUNCOUNT;
        end else if (card > ARRAY_MAX) begin
          ph_nxt = PH_BITMAP;
        end else begin
          ph_nxt = PH_ARRAY;
        end
        st_nxt = S_WORK;
      end
      S_WORK: begin
        if (!(may_emit && pend_v_r && !out_free)) begin
          unique case (ph_r)
            PH_COOKIE: begin
              asm_nxt = asm_g; sbc_nxt = sbc_p1;
              if (sbc_p1 >= SBW'(4)) begin
                asm_nxt = '0; sbc_nxt = '0;
                if (asm_g[15:0] == COOKIE_RUNS) begin
                  runs_nxt = 1'b1;
                  tot_nxt  = {1'b0, asm_g[31:16]} + 17'd1;
                  if (tot_nxt > MAXC) begin
                    err_nxt = ST_LIMIT; ph_nxt = PH_HALT;
                  end else begin
                    ph_nxt = PH_FLAGS;
                  end
                end else if (asm_g == COOKIE_PLAIN) begin
                  ph_nxt = PH_COUNT;
                end else begin
                  err_nxt = ST_COOKIE; ph_nxt = PH_HALT;
                end
              end
            end
            PH_COUNT: begin
              asm_nxt = asm_g; sbc_nxt = sbc_p1;
              if (sbc_p1 >= SBW'(4)) begin
                if (asm_g > 32'(MAX_CONTAINERS)) begin
                  err_nxt = ST_LIMIT; ph_nxt = PH_HALT;
                end else begin
                  tot_nxt  = asm_g[16:0];
                  do_bdesc = 1'b1;
                end
              end
            end
            PH_FLAGS: begin
              flag_we = 1'b1;
              sbc_nxt = sbc_p1;
              if (sbc_p1 >= ((SBW'(tot_r) + SBW'(7)) >> 3)) begin
                do_bdesc = 1'b1;
              end
            end
            PH_DESC: begin
              asm_nxt = asm_g; sbc_nxt = sbc_p1;
              if (sbc_p1 >= SBW'(4)) begin
                desc_we  = 1'b1;
                desc_wd  = {asm_g[15:0], asm_g[31:16]};
                dsum_nxt = dsum_r + {17'd0, asm_g[31:16]} + 33'd1;
                asm_nxt  = '0; sbc_nxt = '0;
                idx_nxt  = idx_r + 17'd1;
                if (idx_nxt >= tot_r) begin
                  do_offs = 1'b1;
                end
              end
            end
            PH_OFFSETS: begin
              sbc_nxt = sbc_p1;
              if (sbc_p1 >= {tot_r, 2'b00}) begin
                do_fin = 1'b1;
              end
            end
            PH_RUNCOUNT: begin
              asm_nxt = asm_g; sbc_nxt = sbc_p1;
              if (sbc_p1 >= SBW'(2)) begin
                rl_nxt = asm_g[15:0];
                asm_nxt = '0; sbc_nxt = '0;
                if (asm_g[15:0] == 16'd0) begin
                  do_end = 1'b1;
                end else begin
                  ph_nxt = PH_RUNS;
                end
              end
            end
            PH_RUNS: begin
              asm_nxt = asm_g; sbc_nxt = sbc_p1;
              if (sbc_p1 >= SBW'(4)) begin
                asm_nxt = '0; sbc_nxt = '0;
                em_low = asm_g[15:0];
                em_cnt = {1'b0, asm_g[31:16]} + 17'd1;
                chk = em_check(em_low, em_cnt, key, esum_r, nmin_r, bud);
                if (chk != ST_OK) begin
                  err_nxt = chk; ph_nxt = PH_HALT;
                end else begin
                  em_do  = 1'b1;
                  rl_nxt = rl_r - 16'd1;
                  if (rl_nxt == 16'd0) begin
                    do_end = 1'b1;
                  end
                end
              end
            end
            PH_BITMAP: begin
              if (!bit_f) begin
                sbc_nxt = sbc_p1;
                if (sbc_p1 >= BITMAP_BYTES) begin
                  do_end = 1'b1;
                end
              end else if (cvc_r >= card) begin
                err_nxt = ST_CARD; ph_nxt = PH_HALT;
              end else begin
                em_low = {sbc_r[12:0], bit_i};
                em_cnt = 17'd1;
                chk = em_check(em_low, em_cnt, key, esum_r, nmin_r, bud);
                if (chk != ST_OK) begin
                  err_nxt = chk; ph_nxt = PH_HALT;
                end else begin
                  em_do = 1'b1;
                  mask_nxt = mask_r & ~(8'd1 << bit_i);
                  wdone = 1'b0;
                end
              end
            end
            PH_ARRAY: begin
              sbc_nxt = sbc_p1;
              if (!sbc_r[0]) begin
                asm_nxt = {24'd0, byte_r};
              end else begin
                asm_nxt = asm_r | {16'd0, byte_r, 8'd0};
                em_low = asm_nxt[15:0];
                em_cnt = 17'd1;
                chk = em_check(em_low, em_cnt, key, esum_r, nmin_r, bud);
                if (chk != ST_OK) begin
                  err_nxt = chk; ph_nxt = PH_HALT;
                end else begin
                  em_do = 1'b1;
                  if (sbc_p1 >= SBW'({card, 1'b0})) begin
                    do_end = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase

          if (em_do) begin
            em_start = {key, 16'd0} + {16'd0, em_low};
            esum_nxt = esum_r + {16'd0, em_cnt};
            nmin_nxt = {1'b0, em_start} + {16'd0, em_cnt};
            cvc_s    = {1'b0, cvc_r} + {1'b0, em_cnt};
            cvc_nxt  = cvc_s[17] ? 17'h1FFFF : cvc_s[16:0];
            if (pend_v_r) begin
              out_load = 1'b1; ld_kind = KIND_RANGE; ld_last = 1'b0;
              ld_start = pend_start_r; ld_cnt = pend_cnt_r; ld_st = ST_OK;
            end
            pend_v_nxt = 1'b1; pend_start_nxt = em_start; pend_cnt_nxt = em_cnt;
          end

          // Container and header transitions.
          if (do_end) begin
            if (cvc_nxt != card) begin
              err_nxt = ST_CARD; ph_nxt = PH_HALT;
            end else begin
              idx_nxt = idx_r + 17'd1; do_begin = 1'b1;
            end
          end
          if (do_bdesc) begin
            idx_nxt = '0; sbc_nxt = '0; asm_nxt = '0;
            if (tot_nxt == 17'd0) begin
              do_offs = 1'b1;
            end else begin
              ph_nxt = PH_DESC;
            end
          end
          if (do_offs) begin
            sbc_nxt = '0;
            if ((!runs_r || tot_nxt >= OFFSET_MIN) && tot_nxt != 17'd0) begin
              ph_nxt = PH_OFFSETS;
            end else begin
              do_fin = 1'b1;
            end
          end
          if (do_fin) begin
            if (dsum_nxt > bud) begin
              err_nxt = ST_OVER; ph_nxt = PH_HALT;
            end else begin
              idx_nxt = '0; do_begin = 1'b1;
            end
          end
          if (do_begin) begin
            if (idx_nxt >= tot_nxt) begin
              ph_nxt = PH_DONE;
            end else begin
              cvc_nxt = '0; sbc_nxt = '0; asm_nxt = '0;
              ph_nxt = PH_BEGIN;
            end
          end
          if (wdone) begin
            st_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_load = 1'b1; ld_kind = KIND_RANGE; ld_last = !eof_r;
            ld_start = pend_start_r; ld_cnt = pend_cnt_r; ld_st = ST_OK;
            pend_v_nxt = 1'b0;
          end
          if (eof_r) begin
            st_nxt = S_STAT;
          end else begin
            do_take = 1'b1;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          if (err_r != ST_OK) begin
            fstat = err_r;
          end else if (ph_r == PH_DONE) begin
            fstat = ST_OK;
          end else begin
            fstat = ST_TRUNC;
          end
          out_load = 1'b1; ld_kind = KIND_STATUS; ld_last = 1'b1;
          ld_start = '0; ld_cnt = '0; ld_st = fstat;
          // The next bitmap starts from a clean parse state.
          ph_nxt = PH_COOKIE; asm_nxt = '0; sbc_nxt = '0; tot_nxt = '0;
          idx_nxt = '0; runs_nxt = 1'b0; rl_nxt = '0; cvc_nxt = '0;
          dsum_nxt = '0; esum_nxt = '0; nmin_nxt = '0; err_nxt = ST_OK;
          ph_take = PH_COOKIE;
          do_take = 1'b1;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (do_take) begin
      if (head.valid) begin
        pop = 1'b1;
        byte_nxt = head.item.data;
        eof_nxt  = head.item.eof;
        mask_nxt = head.item.data;
        st_nxt = (ph_take == PH_BEGIN) ? S_FETCH : S_WORK;
      end else begin
        st_nxt = S_IDLE;
      end
    end
  end

  // Descriptor and run-flag stores; read port follows the container index.
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[idx_r[DAW-1:0]] <= desc_wd;
    end
    desc_q_r <= desc_mem[idx_r[DAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[sbc_r[FAW-1:0]] <= byte_r;
    end
    flag_q_r <= flag_mem[FAW'(idx_r >> 3)];
    fsel_r   <= idx_r[2:0];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= ld_kind;
      out_last_r  <= ld_last;
      out_start_r <= ld_start;
      out_cnt_r   <= ld_cnt;
      out_st_r    <= ld_st;
    end
    byte_r <= byte_nxt;
    eof_r  <= eof_nxt;
    mask_r <= mask_nxt;
    pend_start_r <= pend_start_nxt;
    pend_cnt_r   <= pend_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_COOKIE; asm_r <= '0; sbc_r <= '0;
      tot_r <= '0; idx_r <= '0; runs_r <= 1'b0; rl_r <= '0; cvc_r <= '0;
      dsum_r <= '0; esum_r <= '0; nmin_r <= '0; err_r <= ST_OK;
      pend_v_r <= 1'b0; out_valid_r <= 1'b0; budget_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; asm_r <= asm_nxt; sbc_r <= sbc_nxt;
      tot_r <= tot_nxt; idx_r <= idx_nxt; runs_r <= runs_nxt; rl_r <= rl_nxt;
      cvc_r <= cvc_nxt; dsum_r <= dsum_nxt; esum_r <= esum_nxt; nmin_r <= nmin_nxt;
      err_r <= err_nxt; pend_v_r <= pend_v_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_range_start = out_start_r;
  assign out_range_count = out_cnt_r;
  assign out_status      = out_st_r;
  assign out_last_result = out_last_r;

  `RBSD_ASSERT_IMP(a_err_halts, err_r != ST_OK, ph_r == PH_HALT, "error recorded without halt")
  `RBSD_ASSERT_IMP(a_idle_no_pend, st_r == S_IDLE, !pend_v_r, "held range left while idle")
  `RBSD_ASSERT_NXT(a_stat_restart, (st_r == S_STAT) && out_free, ph_r == PH_COOKIE, "no restart after status")

endmodule
